### rtl/assert_macros.svh
// Assertion macros used by the meter controller RTL.
// With SYNTH defined every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/tcem_pkg.sv
package tcem_pkg;

    localparam int NUM_CH     = 3;
    localparam int CODE_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;

    localparam logic [15:0] GAIN_RESET = 16'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_GAIN0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_GAIN1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_GAIN2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURR_GAIN0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CURR_GAIN1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CURR_GAIN2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CURR_ZERO  = 3'd6;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_ZERO   = 1'b1;

    typedef enum logic [1:0] {
        MUL_VOLT,
        MUL_AMP,
        MUL_PWR,
        MUL_ENG
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_AMP,
        S_SAT,
        S_ZERO,
        S_PWR,
        S_ENG,
        S_ACC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic     capture;
        mul_sel_t mul_sel;
        logic     ld_volt;
        logic     ld_amp;
        logic     ld_stored;
        logic     ld_pwr;
        logic     wr_sample;
        logic     ld_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_zero;
        logic bad_ch;
        logic out_free;
    } ctrl_status_t;

endpackage

### rtl/tcem_ctrl.sv
`include "assert_macros.svh"

module tcem_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tcem_pkg::ctrl_status_t status,
    output tcem_pkg::ctrl_cmd_t    cmd
);
    import tcem_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_VOLT;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                // The voltage product is formed here whatever the command.
                cmd.mul_sel = MUL_VOLT;
                priority if (status.bad_ch) begin
                    state_next = S_DONE;
                end else if (status.is_zero) begin
                    state_next = S_ZERO;
                end else begin
                    state_next = S_AMP;
                end
            end
            S_AMP: begin
                cmd.mul_sel = MUL_AMP;
                cmd.ld_volt = 1'b1;
                state_next  = S_SAT;
            end
            S_SAT: begin
                cmd.ld_amp = 1'b1;
                state_next = S_PWR;
            end
            S_ZERO: begin
                cmd.ld_stored = 1'b1;
                state_next    = S_PWR;
            end
            S_PWR: begin
                cmd.mul_sel = MUL_PWR;
                state_next  = S_ENG;
            end
            S_ENG: begin
                cmd.mul_sel = MUL_ENG;
                cmd.ld_pwr  = 1'b1;
                priority if (status.is_zero) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                cmd.wr_sample = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.ld_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ASSERT_RST(a_out_free, aclk, aresetn, cmd.ld_out |-> status.out_free, "result overwritten")
    `ASSERT_RST(a_wr_sample, aclk, aresetn, cmd.wr_sample |-> (!status.bad_ch && !status.is_zero), "bad sample write")
    `ASSERT_RST(a_accept_decode, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == S_DECODE), "accept lost")
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (state_reg == S_IDLE), "reset not idle")

endmodule

### rtl/tcem_datapath.sv
module tcem_datapath #(
    parameter int ADC_BITS = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tcem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcem_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_cmd,
    input  logic [1:0]                        s_channel,
    input  logic [tcem_pkg::CODE_W-1:0]       s_volt_code,
    input  logic [tcem_pkg::CODE_W-1:0]       s_amp_code,
    input  logic [15:0]                       s_elapsed_ms,
    input  tcem_pkg::ctrl_cmd_t               cmd,
    output tcem_pkg::ctrl_status_t            status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_out_channel,
    output logic [15:0]                       m_volt_mv,
    output logic signed [17:0]                m_amp_ma,
    output logic signed [33:0]                m_power_uw,
    output logic signed [63:0]                m_energy_nj
);
    import tcem_pkg::*;

    localparam logic [CODE_W-1:0] CODE_MASK =
        (ADC_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((1 << ADC_BITS) - 1);

    function automatic logic signed [17:0] sat18(input logic signed [18:0] v);
        logic signed [17:0] r;
        if (v[18] != v[17]) begin
            r = v[18] ? 18'sh20000 : 18'sh1FFFF;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic [15:0]           volt_gain_reg [NUM_CH];
    logic [15:0]           curr_gain_reg [NUM_CH];
    logic [CFG_DATA_W-1:0] zero_codes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CH; c++) begin
                volt_gain_reg[c] <= GAIN_RESET;
                curr_gain_reg[c] <= GAIN_RESET;
            end
            zero_codes_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_VOLT_GAIN0: volt_gain_reg[0] <= cfg_wdata[15:0];
                CFG_VOLT_GAIN1: volt_gain_reg[1] <= cfg_wdata[15:0];
                CFG_VOLT_GAIN2: volt_gain_reg[2] <= cfg_wdata[15:0];
                CFG_CURR_GAIN0: curr_gain_reg[0] <= cfg_wdata[15:0];
                CFG_CURR_GAIN1: curr_gain_reg[1] <= cfg_wdata[15:0];
                CFG_CURR_GAIN2: curr_gain_reg[2] <= cfg_wdata[15:0];
                CFG_CURR_ZERO:  zero_codes_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Captured transaction
    logic              cmd_reg;
    logic [1:0]        ch_reg;
    logic [CODE_W-1:0] vcode_reg;
    logic [CODE_W-1:0] acode_reg;
    logic [15:0]       ms_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg   <= s_cmd;
            ch_reg    <= s_channel;
            vcode_reg <= s_volt_code & CODE_MASK;
            acode_reg <= s_amp_code & CODE_MASK;
            ms_reg    <= s_elapsed_ms;
        end
    end

    // Per-channel state
    logic [15:0]        volt_store_reg   [NUM_CH];
    logic signed [17:0] amp_store_reg    [NUM_CH];
    logic signed [17:0] offset_store_reg [NUM_CH];
    logic signed [63:0] energy_store_reg [NUM_CH];

    logic               bad_ch;
    logic [15:0]        vgain_rd, cgain_rd, volt_rd;
    logic [CODE_W-1:0]  zero_rd;
    logic signed [17:0] amp_rd, off_rd;
    logic signed [63:0] energy_rd;

    assign bad_ch = (ch_reg >= 2'(NUM_CH));

    always_comb begin
        vgain_rd  = '0;
        cgain_rd  = '0;
        zero_rd   = '0;
        volt_rd   = '0;
        amp_rd    = '0;
        off_rd    = '0;
        energy_rd = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            if (ch_reg == 2'(c)) begin
                vgain_rd  = volt_gain_reg[c];
                cgain_rd  = curr_gain_reg[c];
                zero_rd   = zero_codes_reg[c*CODE_W +: CODE_W];
                volt_rd   = volt_store_reg[c];
                amp_rd    = amp_store_reg[c];
                off_rd    = offset_store_reg[c];
                energy_rd = energy_store_reg[c];
            end
        end
    end

    // Shared multiplier, one product per step
    logic signed [CODE_W:0] diff;
    logic signed [34:0]     mul_a;
    logic signed [16:0]     mul_b;
    logic signed [51:0]     prod_reg;
    logic [15:0]            volt_reg;
    logic signed [17:0]     amp_reg;
    logic signed [33:0]     pwr_reg;

    assign diff = $signed({1'b0, acode_reg}) - $signed({1'b0, zero_rd});

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_VOLT: begin
                mul_a = $signed({{(35-CODE_W){1'b0}}, vcode_reg});
                mul_b = $signed({1'b0, vgain_rd});
            end
            MUL_AMP: begin
                mul_a = 35'(diff);
                mul_b = $signed({1'b0, cgain_rd});
            end
            MUL_PWR: begin
                mul_a = 35'(amp_reg);
                mul_b = $signed({1'b0, volt_reg});
            end
            MUL_ENG: begin
                mul_a = 35'($signed(prod_reg[33:0]));
                mul_b = $signed({1'b0, ms_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    logic signed [18:0] amp_sum;
    logic signed [18:0] off_diff;
    logic signed [64:0] energy_sum;
    logic signed [63:0] energy_next;

    // The scaled current fits 18 bits, so bits [27:10] are the floored quotient.
    assign amp_sum    = 19'($signed(prod_reg[27:10])) + 19'(off_rd);
    assign off_diff   = 19'(off_rd) - 19'(amp_rd);
    assign energy_sum = 65'(energy_rd) + 65'($signed(prod_reg[49:0]));

    always_comb begin
        if (energy_sum[64] != energy_sum[63]) begin
            energy_next = energy_sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
            energy_next = energy_sum[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_volt) begin
            volt_reg <= (|prod_reg[51:26]) ? 16'hFFFF : prod_reg[25:10];
        end else if (cmd.ld_stored) begin
            volt_reg <= volt_rd;
        end
        if (cmd.ld_amp) begin
            amp_reg <= sat18(amp_sum);
        end else if (cmd.ld_stored) begin
            amp_reg <= amp_rd;
        end
        if (cmd.ld_pwr) begin
            pwr_reg <= prod_reg[33:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CH; c++) begin
                volt_store_reg[c]   <= '0;
                amp_store_reg[c]    <= '0;
                offset_store_reg[c] <= '0;
                energy_store_reg[c] <= '0;
            end
        end else begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (ch_reg == 2'(c)) begin
                    if (cmd.wr_sample) begin
                        volt_store_reg[c]   <= volt_reg;
                        amp_store_reg[c]    <= amp_reg;
                        energy_store_reg[c] <= energy_next;
                    end
                    if (cmd.ld_stored) begin
                        offset_store_reg[c] <= sat18(off_diff);
                    end
                end
            end
        end
    end

    // Output register; it holds a finished transaction while the next one runs.
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.ld_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_out) begin
            m_out_channel <= ch_reg;
            m_volt_mv     <= bad_ch ? '0 : volt_reg;
            m_amp_ma      <= bad_ch ? '0 : amp_reg;
            m_power_uw    <= bad_ch ? '0 : pwr_reg;
            m_energy_nj   <= bad_ch ? '0 : energy_rd;
        end
    end

    assign m_valid         = m_valid_reg;
    assign status.is_zero  = (cmd_reg == CMD_ZERO);
    assign status.bad_ch   = bad_ch;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

### rtl/three_channel_energy_meter.sv
// Sample transaction: accepted in idle, then decode, amp, sat, pwr, eng, acc and done states.
// Zero transaction: decode, zero, pwr, eng and done; unknown channel: decode and done.
// Done waits for a free output register; the next transaction is accepted back in idle.
// One shared 35x17 multiplier forms the voltage, current, power and energy products in turn.
// Reset (aresetn low, synchronous) sets gains to 1024, zero codes and all channel
// state to zero, and empties the output register.
module three_channel_energy_meter #(
    parameter int ADC_BITS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tcem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcem_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [1:0]                      s_channel,
    input  logic [tcem_pkg::CODE_W-1:0]     s_volt_code,
    input  logic [tcem_pkg::CODE_W-1:0]     s_amp_code,
    input  logic [15:0]                     s_elapsed_ms,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_out_channel,
    output logic [15:0]                     m_volt_mv,
    output logic signed [17:0]              m_amp_ma,
    output logic signed [33:0]              m_power_uw,
    output logic signed [63:0]              m_energy_nj
);
    import tcem_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    tcem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcem_datapath #(
        .ADC_BITS (ADC_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_cmd         (s_cmd),
        .s_channel     (s_channel),
        .s_volt_code   (s_volt_code),
        .s_amp_code    (s_amp_code),
        .s_elapsed_ms  (s_elapsed_ms),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_volt_mv     (m_volt_mv),
        .m_amp_ma      (m_amp_ma),
        .m_power_uw    (m_power_uw),
        .m_energy_nj   (m_energy_nj)
    );

endmodule
